>>> rtl/dpar_pkg.sv
// ----------------------------------------------------------------------------
// dpar_pkg
// shared widths, codes and the job type passed from the parser to the divider
// ----------------------------------------------------------------------------
package dpar_pkg;

    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 31;
    localparam int DIGIT_W     = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int MAX_NUMBERS = 256;
    localparam int COUNT_W     = $clog2(MAX_NUMBERS + 1);
    localparam int SUM_W       = 39;
    localparam int FRAC_W      = 8;
    localparam int AVG_W       = 39;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 3;
    localparam int RING_DEPTH  = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_BITS    = SUM_W + FRAC_W;
    localparam int STEP_W      = $clog2(DIV_BITS);
    localparam int OUT_TDATA_W = 48;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // one finished packet, as handed to the back end
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_back_state;

endpackage

>>> rtl/dpar_front.sv
// ----------------------------------------------------------------------------
// dpar_front
// byte parser: builds decimal numbers, sums and counts them per packet
// ----------------------------------------------------------------------------
module dpar_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dpar_pkg::CHAR_W-1:0]  i_char,
    input  logic                         i_last,
    output logic                         o_job_valid,
    input  logic                         i_job_ready,
    output dpar_pkg::t_job               o_job
);

    logic [dpar_pkg::VALUE_W-1:0] r_value, n_value;
    logic [dpar_pkg::DIGIT_W-1:0] r_digits, n_digits;
    logic [dpar_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [dpar_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_ovf, n_ovf;

    logic                         w_digit;
    logic [dpar_pkg::VALUE_W+3:0] w_scaled;
    logic [dpar_pkg::VALUE_W-1:0] w_value_upd;
    logic [dpar_pkg::VALUE_W-1:0] w_close_value;
    logic                         w_close;
    logic                         w_room;
    logic                         w_accept;

    assign o_ready  = i_job_ready;
    assign w_accept = i_valid && i_job_ready;

    assign w_digit  = (i_char >= dpar_pkg::CHAR_ZERO) && (i_char <= dpar_pkg::CHAR_NINE);
    // value * 10 + digit as shift-add
    assign w_scaled = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1)
                    + {{(dpar_pkg::VALUE_W){1'b0}}, i_char[3:0]};
    assign w_value_upd = (w_scaled > {4'b0, dpar_pkg::VALUE_MAX})
                       ? dpar_pkg::VALUE_MAX : w_scaled[dpar_pkg::VALUE_W-1:0];

    // a digit closes its number only on the last byte; a separator closes any open one
    assign w_close_value = w_digit ? w_value_upd : r_value;
    assign w_close       = w_digit ? i_last : (r_digits != '0);
    assign w_room        = r_count < dpar_pkg::COUNT_W'(dpar_pkg::MAX_NUMBERS);

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_close && w_room) begin
            n_sum   = r_sum + {{(dpar_pkg::SUM_W-dpar_pkg::VALUE_W){1'b0}}, w_close_value};
            n_count = r_count + 1'b1;
        end else if (w_close) begin
            n_ovf = 1'b1;
        end
        if (w_digit) begin
            n_value  = w_value_upd;
            n_digits = (r_digits < dpar_pkg::DIGIT_W'(dpar_pkg::MAX_DIGITS))
                     ? r_digits + 1'b1 : r_digits;
        end else begin
            n_value  = '0;
            n_digits = '0;
        end
    end

    assign o_job_valid    = i_valid && i_last;
    assign o_job.sum      = n_sum;
    assign o_job.count    = n_count;
    assign o_job.overflow = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value  <= '0;
            r_digits <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_value  <= '0;
                r_digits <= '0;
                r_sum    <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_value  <= n_value;
                r_digits <= n_digits;
                r_sum    <= n_sum;
                r_count  <= n_count;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

>>> rtl/dpar_queue.sv
// ----------------------------------------------------------------------------
// dpar_queue
// short job queue between the parser and the divider
// ----------------------------------------------------------------------------
module dpar_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_not_full,
    input  dpar_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_not_empty,
    output dpar_pkg::t_job o_job
);

    dpar_pkg::t_job r_mem [dpar_pkg::QUEUE_DEPTH];
    logic [dpar_pkg::QPTR_W-1:0] r_wptr;
    logic [dpar_pkg::QPTR_W-1:0] r_rptr;
    logic [dpar_pkg::QCNT_W-1:0] r_cnt;
    logic                        w_push;
    logic                        w_pop;

    assign o_not_full  = r_cnt != dpar_pkg::QCNT_W'(dpar_pkg::QUEUE_DEPTH);
    assign o_not_empty = r_cnt != '0;
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_job       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == dpar_pkg::QPTR_W'(dpar_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == dpar_pkg::QPTR_W'(dpar_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/dpar_back.sv
// ----------------------------------------------------------------------------
// dpar_back
// bit-serial divider, average ring and result register
// ----------------------------------------------------------------------------
module dpar_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    output logic                             o_job_pop,
    input  dpar_pkg::t_job                   i_job,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dpar_pkg::OUT_TDATA_W-1:0] o_out_data
);

    dpar_pkg::t_back_state r_state, n_state;

    logic [dpar_pkg::DIV_BITS-1:0] r_quo;
    logic [dpar_pkg::COUNT_W-1:0]  r_rem;
    logic [dpar_pkg::COUNT_W-1:0]  r_divisor;
    logic                          r_ovf;
    logic [dpar_pkg::STEP_W-1:0]   r_step;

    logic [dpar_pkg::AVG_W-1:0]    r_ring [dpar_pkg::RING_DEPTH];
    logic [dpar_pkg::SLOT_W-1:0]   r_oldest;
    logic [dpar_pkg::SLOT_W-1:0]   r_fill;

    logic                             r_out_valid;
    logic [dpar_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                          w_load;
    logic                          w_shift;
    logic                          w_commit;
    logic [dpar_pkg::COUNT_W:0]    w_trial;
    logic                          w_ge;
    logic                          w_empty;
    logic                          w_out_free;
    logic [dpar_pkg::SLOT_W-1:0]   w_slot;
    logic [dpar_pkg::SLOT_W-1:0]   w_fill_after;
    logic [dpar_pkg::AVG_W-1:0]    w_avg;
    logic [dpar_pkg::STATUS_W-1:0] w_status;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_empty    = r_divisor == '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dpar_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.count == '0) ? dpar_pkg::ST_FINISH : dpar_pkg::ST_DIVIDE;
                end
            end
            dpar_pkg::ST_DIVIDE: begin
                if (r_step == '0) begin
                    n_state = dpar_pkg::ST_FINISH;
                end
            end
            dpar_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = dpar_pkg::ST_IDLE;
                end
            end
            default: n_state = dpar_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_load   = 1'b0;
        w_shift  = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            dpar_pkg::ST_IDLE:   w_load   = i_job_valid;
            dpar_pkg::ST_DIVIDE: w_shift  = 1'b1;
            dpar_pkg::ST_FINISH: w_commit = w_out_free;
            default: ;
        endcase
    end

    assign o_job_pop = w_load;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[dpar_pkg::DIV_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_quo     <= {i_job.sum, {dpar_pkg::FRAC_W{1'b0}}};
            r_rem     <= '0;
            r_divisor <= i_job.count;
            r_ovf     <= i_job.overflow;
            r_step    <= dpar_pkg::STEP_W'(dpar_pkg::DIV_BITS - 1);
        end else if (w_shift) begin
            r_quo  <= {r_quo[dpar_pkg::DIV_BITS-2:0], w_ge};
            r_rem  <= w_ge ? dpar_pkg::COUNT_W'(w_trial - {1'b0, r_divisor})
                           : w_trial[dpar_pkg::COUNT_W-1:0];
            r_step <= r_step - 1'b1;
        end
    end

    // slot choice: fill in order, then overwrite the oldest
    always_comb begin
        w_slot       = '0;
        w_fill_after = r_fill;
        w_avg        = '0;
        w_status     = dpar_pkg::STATUS_EMPTY;
        if (!w_empty) begin
            w_avg    = r_quo[dpar_pkg::AVG_W-1:0];
            w_status = r_ovf ? dpar_pkg::STATUS_OVERFLOW : dpar_pkg::STATUS_OK;
            if (r_fill < dpar_pkg::SLOT_W'(dpar_pkg::RING_DEPTH)) begin
                w_slot       = r_fill;
                w_fill_after = r_fill + 1'b1;
            end else begin
                w_slot = r_oldest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && !w_empty) begin
            r_ring[w_slot] <= w_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpar_pkg::ST_IDLE;
            r_oldest <= '0;
            r_fill   <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit && !w_empty) begin
                r_fill <= w_fill_after;
                if (r_fill == dpar_pkg::SLOT_W'(dpar_pkg::RING_DEPTH)) begin
                    r_oldest <= (r_oldest == dpar_pkg::SLOT_W'(dpar_pkg::RING_DEPTH - 1))
                              ? '0 : r_oldest + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= {1'b0, w_fill_after, w_slot, w_status, w_avg};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (!r_out_valid || i_out_ready))
        else $error("result committed over an untaken result");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dpar_pkg::SLOT_W'(dpar_pkg::RING_DEPTH))
        else $error("ring fill beyond depth");

    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < dpar_pkg::SLOT_W'(dpar_pkg::RING_DEPTH)) |-> (r_oldest == '0))
        else $error("oldest pointer moved before ring full");

    a_divide_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dpar_pkg::ST_DIVIDE) |-> (r_divisor != '0))
        else $error("division started with a zero count");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state != dpar_pkg::ST_IDLE))
        else $error("job popped without leaving idle");
`endif

endmodule

>>> rtl/decimal_packet_average_ring.sv
// ----------------------------------------------------------------------------
// decimal_packet_average_ring
// decimal number averaging over text packets, with a ring of recent averages
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one text byte per request, tlast on the final byte of a
//   packet. runs of ascii digits form numbers (saturating at 2^31-1), any
//   other byte separates them. m_axis carries one result per packet.
// flow:
//   the parser takes one byte per cycle. on tlast the packet sum and count
//   go into a two-entry job queue; the back end loads a job, divides sum*256
//   by count one quotient bit per cycle, then commits the result once the
//   output register is free (a packet with no numbers skips the divide).
//   the parser keeps running while the back end divides; it stalls only
//   when both queue entries are taken.
// reset:
//   synchronous active low; clears the parser, the queue, the divider state
//   and the ring pointers. ring contents are left as they were.
// stalls:
//   the result sits in an output register until m_axis_tready; the divider
//   may finish the next packet meanwhile and then holds it until the
//   register frees, and the queue then backs up into s_axis_tready.
// ----------------------------------------------------------------------------
module decimal_packet_average_ring (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] char_byte
    input  logic [7:0]                       s_axis_tdata,
    // last_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [38:0] average_fixed, [40:39] status_code, [43:41] slot_written,
    // [46:44] stored_total, [47] zero
    output logic [dpar_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // parser to queue
    logic           w_push;
    logic           w_not_full;
    dpar_pkg::t_job w_push_job;

    // queue to divider
    logic           w_pop;
    logic           w_not_empty;
    dpar_pkg::t_job w_pop_job;

    // front end: number parsing and per-packet accumulation
    dpar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_job_valid (w_push),
        .i_job_ready (w_not_full),
        .o_job       (w_push_job)
    );

    // finished packets waiting for the divider
    dpar_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_not_full  (w_not_full),
        .i_job       (w_push_job),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_job       (w_pop_job)
    );

    // back end: divide, store in ring, present result
    dpar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_not_empty),
        .o_job_pop   (w_pop),
        .i_job       (w_pop_job),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> sim/tb_decimal_packet_average_ring.sv
// ----------------------------------------------------------------------------
// tb_decimal_packet_average_ring
// self-checking bench for the decimal packet averager and its ring of results
// ----------------------------------------------------------------------------
// text packets are sent byte by byte on s_axis. every accepted request is fed
// to an in-bench model of the number parser, the packet average and the ring
// pointers, which queues the result expected for each packet. results taken
// from m_axis are checked field by field against the oldest queued one.
// tests: directed corner cases, the numbers-per-packet limit, a back-to-back
// stretch, a long output hold-off that backs up the input, and random packets.
// ----------------------------------------------------------------------------
module tb_decimal_packet_average_ring;

    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 600;
    localparam int B2B_PACKETS   = 12;
    localparam int RANDOM_ITEMS  = 250;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    // one packet result as it leaves the block
    typedef struct packed {
        logic [dpar_pkg::AVG_W-1:0]    average;
        logic [dpar_pkg::STATUS_W-1:0] status;
        logic [dpar_pkg::SLOT_W-1:0]   slot;
        logic [dpar_pkg::SLOT_W-1:0]   total;
    } t_avg_result;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata  = '0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dpar_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // parser and ring model state
    logic [dpar_pkg::VALUE_W-1:0] cur_value;
    logic [dpar_pkg::DIGIT_W-1:0] cur_digits;
    logic [dpar_pkg::SUM_W-1:0]   pkt_sum;
    logic [dpar_pkg::COUNT_W-1:0] pkt_count;
    logic                         pkt_overflow;
    logic [dpar_pkg::SLOT_W-1:0]  ring_oldest;
    logic [dpar_pkg::SLOT_W-1:0]  ring_fill;

    t_avg_result avg_pending_q[$];
    logic [7:0]  pkt_chars[$];

    t_avg_result got_result;
    t_avg_result want_result;

    bit steady        = 1'b0;
    int hold_requests = 0;
    int holds_served  = 0;

    int errors          = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int packets_sent    = 0;
    int results_checked = 0;
    int empty_results   = 0;
    int limit_results   = 0;
    int stall_cycles    = 0;

    decimal_packet_average_ring dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (s_axis_tvalid && !s_axis_tready && i_rst_n)
            stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, avg_pending_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic void reset_model();
        cur_value    = '0;
        cur_digits   = '0;
        pkt_sum      = '0;
        pkt_count    = '0;
        pkt_overflow = 1'b0;
        ring_oldest  = '0;
        ring_fill    = '0;
    endfunction

    function automatic void close_number();
        if (cur_digits != 0) begin
            if (pkt_count < dpar_pkg::MAX_NUMBERS) begin
                pkt_sum   = pkt_sum + cur_value;
                pkt_count = pkt_count + 1'b1;
            end else begin
                pkt_overflow = 1'b1;
            end
            cur_value  = '0;
            cur_digits = '0;
        end
    endfunction

    // takes one accepted request, queues a result at the end of a packet
    function automatic void take_char(input logic [7:0] ch, input logic last);
        logic [dpar_pkg::VALUE_W+3:0]                grown;
        logic [dpar_pkg::SUM_W+dpar_pkg::FRAC_W-1:0] quotient;
        t_avg_result                                 res;
        if (ch >= dpar_pkg::CHAR_ZERO && ch <= dpar_pkg::CHAR_NINE) begin
            grown = cur_value * 35'd10 + (ch - dpar_pkg::CHAR_ZERO);
            cur_value = (grown > dpar_pkg::VALUE_MAX)
                      ? dpar_pkg::VALUE_MAX : grown[dpar_pkg::VALUE_W-1:0];
            if (cur_digits < dpar_pkg::MAX_DIGITS)
                cur_digits = cur_digits + 1'b1;
        end else begin
            close_number();
        end
        if (last) begin
            close_number();
            res = '0;
            if (pkt_count == 0) begin
                res.status = dpar_pkg::STATUS_EMPTY;
            end else begin
                quotient    = {pkt_sum, {dpar_pkg::FRAC_W{1'b0}}} / pkt_count;
                res.average = quotient[dpar_pkg::AVG_W-1:0];
                res.status  = pkt_overflow ? dpar_pkg::STATUS_OVERFLOW : dpar_pkg::STATUS_OK;
                if (ring_fill < dpar_pkg::RING_DEPTH) begin
                    res.slot  = ring_fill;
                    ring_fill = ring_fill + 1'b1;
                end else begin
                    res.slot    = ring_oldest;
                    ring_oldest = (ring_oldest == dpar_pkg::RING_DEPTH - 1)
                                ? '0 : ring_oldest + 1'b1;
                end
            end
            res.total = ring_fill;
            avg_pending_q.push_back(res);
            cur_value    = '0;
            cur_digits   = '0;
            pkt_sum      = '0;
            pkt_count    = '0;
            pkt_overflow = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result.average = m_axis_tdata[38:0];
            got_result.status  = m_axis_tdata[40:39];
            got_result.slot    = m_axis_tdata[43:41];
            got_result.total   = m_axis_tdata[46:44];
            if (avg_pending_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result avg=%0h status=%0d slot=%0d total=%0d",
                             got_result.average, got_result.status,
                             got_result.slot, got_result.total);
            end else begin
                want_result = avg_pending_q.pop_front();
                results_checked++;
                if (want_result.status == dpar_pkg::STATUS_EMPTY)
                    empty_results++;
                if (want_result.status == dpar_pkg::STATUS_OVERFLOW)
                    limit_results++;
                if (got_result.average != want_result.average ||
                    got_result.status  != want_result.status  ||
                    got_result.slot    != want_result.slot    ||
                    got_result.total   != want_result.total) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("result %0d: exp %0h/%0d/%0d/%0d got %0h/%0d/%0d/%0d",
                                 results_checked, want_result.average,
                                 want_result.status, want_result.slot,
                                 want_result.total, got_result.average,
                                 got_result.status, got_result.slot,
                                 got_result.total);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side: random back-pressure, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // called at a rising edge, returns at the edge that accepted the request
    task automatic send_char(input logic [7:0] ch, input logic last);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_sent++;
        take_char(ch, last);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_chars.size(); i++)
            send_char(pkt_chars[i], i == pkt_chars.size() - 1);
        pkt_chars.delete();
        packets_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            pkt_chars.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= dpar_pkg::CHAR_ZERO && c <= dpar_pkg::CHAR_NINE);
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return dpar_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // builds a random packet: mostly numbers with random separators
    task automatic build_random_packet();
        int n_nums;
        int n_digits;
        int k;
        int j;
        if ($urandom_range(0, 99) < 8) begin
            // packet with no digits at all
            n_nums = $urandom_range(1, 4);
            for (k = 0; k < n_nums; k++)
                pkt_chars.push_back(rand_separator());
        end else begin
            n_nums = $urandom_range(1, 6);
            for (k = 0; k < n_nums; k++) begin
                if (k > 0 || $urandom_range(0, 3) == 0)
                    pkt_chars.push_back(rand_separator());
                if ($urandom_range(0, 1) == 0 && k > 0)
                    pkt_chars.push_back(rand_separator());
                if ($urandom_range(0, 9) == 0)
                    n_digits = $urandom_range(10, 13);   // saturating length
                else
                    n_digits = $urandom_range(1, 4);
                if ($urandom_range(0, 7) == 0) begin
                    // leading zeros ahead of the value
                    for (j = 0; j < $urandom_range(1, 8); j++)
                        pkt_chars.push_back(dpar_pkg::CHAR_ZERO);
                end
                for (j = 0; j < n_digits; j++)
                    pkt_chars.push_back(rand_digit());
            end
            // end either on a digit or on a trailing separator
            if ($urandom_range(0, 1) == 0)
                pkt_chars.push_back(rand_separator());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        pkt_chars.push_back(8'h00);          // lone zero byte: no numbers
        send_packet();
        push_text("9");                      // single digit that is the last byte
        send_packet();
        push_text("3");                      // two numbers, fractional average
        pkt_chars.push_back(8'hFF);
        push_text("4");
        send_packet();
        push_text("99999999999");            // saturates, more digits than the limit
        send_packet();
        push_text("0:/");                    // zero value, separators next to digits
        send_packet();
        push_text("5");                      // ring becomes full
        pkt_chars.push_back(8'h7F);
        send_packet();
        push_text("1");                      // first overwrite of the oldest entry
        send_packet();
    endtask

    // exactly the limit, then past it
    task automatic test_number_limit();
        int k;
        int n;
        for (n = dpar_pkg::MAX_NUMBERS; n <= dpar_pkg::MAX_NUMBERS + 2; n += 2) begin
            for (k = 0; k < n; k++) begin
                if (k > 0)
                    pkt_chars.push_back(rand_separator());
                pkt_chars.push_back(rand_digit());
            end
            send_packet();
        end
    endtask

    task automatic test_back_to_back();
        int k;
        steady = 1'b1;
        for (k = 0; k < B2B_PACKETS; k++) begin
            build_random_packet();
            send_packet();
        end
        steady = 1'b0;
    endtask

    // output held off while short packets keep coming
    task automatic test_output_hold();
        int k;
        hold_requests++;
        for (k = 0; k < 30; k++) begin
            pkt_chars.push_back(rand_digit());
            send_packet();
        end
    endtask

    task automatic test_random();
        int start_items;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            build_random_packet();
            send_packet();
        end
    endtask

    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_number_limit();
        test_back_to_back();
        test_output_hold();
        test_random();

        s_axis_tvalid <= 1'b0;
        while (avg_pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        errors += avg_pending_q.size();
        $display("%0d bytes in %0d packets, %0d results checked (%0d empty, %0d over limit)",
                 items_sent, packets_sent, results_checked, empty_results, limit_results);
        $display("%0d input stall cycles, %0d mismatches", stall_cycles, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/dpar_pkg.sv
rtl/dpar_front.sv
rtl/dpar_queue.sv
rtl/dpar_back.sv
rtl/decimal_packet_average_ring.sv
sim/tb_decimal_packet_average_ring.sv
